// File: hw/rtl/msi_pkg.sv
package msi_pkg;

  localparam int VAL_W = 16;
  localparam int ACT_W = 13;
  localparam int ACC_W = 40;
  localparam int PROD_W = 32;

  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_INPUT  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_LAYER_COUNT = 3'd0,
    REG_SIZE0       = 3'd1,
    REG_SIZE1       = 3'd2,
    REG_SIZE2       = 3'd3,
    REG_SIZE3       = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH1,
    ST_FLUSH2,
    ST_DRAIN,
    ST_WB
  } state_t;

  typedef struct packed {
    logic acc_en;
    logic first;
    logic shift;
  } cell_ctl_t;

endpackage

// File: hw/rtl/msi_ram.sv
module msi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/msi_cell.sv
module msi_cell #(
  parameter int WDEPTH = 48,
  parameter int BDEPTH = 3,
  parameter int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1,
  parameter int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1
) (
  input  logic                             clk,
  input  msi_pkg::cell_ctl_t               ctl,
  input  logic                             wt_we,
  input  logic [WAW-1:0]                   wt_waddr,
  input  logic                             bias_we,
  input  logic [BAW-1:0]                   bias_waddr,
  input  logic signed [msi_pkg::VAL_W-1:0] wdata,
  input  logic [WAW-1:0]                   wt_raddr,
  input  logic [BAW-1:0]                   bias_raddr,
  input  logic signed [msi_pkg::VAL_W-1:0] act,
  input  logic signed [msi_pkg::ACC_W-1:0] acc_in,
  output logic signed [msi_pkg::ACC_W-1:0] acc
);
  import msi_pkg::*;

  logic [VAL_W-1:0] wt_rd;
  logic [VAL_W-1:0] bias_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] base;

  msi_ram #(.WIDTH(VAL_W), .DEPTH(WDEPTH), .AW(WAW)) u_wt (
    .clk(clk), .we(wt_we), .waddr(wt_waddr), .wdata(wdata),
    .raddr(wt_raddr), .rdata(wt_rd)
  );

  msi_ram #(.WIDTH(VAL_W), .DEPTH(BDEPTH), .AW(BAW)) u_bias (
    .clk(clk), .we(bias_we), .waddr(bias_waddr), .wdata(wdata),
    .raddr(bias_raddr), .rdata(bias_rd)
  );

  assign base = ctl.first ? {{(ACC_W-VAL_W-12){bias_rd[VAL_W-1]}}, bias_rd, 12'd0} : acc;

  always_ff @(posedge clk) begin
    prod <= act * $signed(wt_rd);
    if (ctl.shift) begin
      acc <= acc_in;
    end else if (ctl.acc_en) begin
      acc <= base + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

endmodule

// File: hw/rtl/msi_sigmoid.sv
module msi_sigmoid #(
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             load,
  input  logic signed [msi_pkg::ACC_W-1:0] acc,
  output logic [msi_pkg::ACT_W-1:0]        result
);
  import msi_pkg::*;

  localparam int IDX_W = $clog2(SIGMOID_TABLE_DEPTH);

  typedef logic [ACT_W-1:0] tab_t [SIGMOID_TABLE_DEPTH];

  // ROM contents only, evaluated at elaboration
  function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] dvs);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], num[b]};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] sig_pos(input logic [63:0] m);
    logic [63:0] y;
    logic [63:0] sum;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    y = m << 13;
    sum = 64'd1 << 28;
    term = 64'd1 << 28;
    for (int n = 1; n <= 20; n++) begin
      term = udiv((term * y) >> 28, 64'(n));
      sum = sum + term;
    end
    e = udiv(64'd1 << 56, sum);
    for (int n = 0; n < 3; n++) begin
      e = (e * e) >> 28;
    end
    den = (64'd1 << 28) + e;
    return udiv((64'd1 << 40) + (den >> 1), den);
  endfunction

  function automatic tab_t build_table();
    tab_t t;
    int xq;
    for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++) begin
      xq = -32768 + int'(udiv(64'((2 * i + 1) * 32768), 64'(SIGMOID_TABLE_DEPTH)));
      if (xq >= 0) begin
        t[i] = ACT_W'(sig_pos(64'(xq)));
      end else begin
        t[i] = ACT_W'(64'd4096 - sig_pos(64'(-xq)));
      end
    end
    return t;
  endfunction

  localparam tab_t SIG_TABLE = build_table();

  logic signed [ACC_W-1:0] rounded;
  logic [VAL_W-1:0] q;
  logic [31:0] scaled;
  logic [IDX_W-1:0] idx;

  always_comb begin
    rounded = (acc + ACC_W'(2048)) >>> 12;
    if (acc < -(ACC_W'(1) <<< 27)) begin
      q = 16'h8000;
    end else if (acc >= (ACC_W'(1) <<< 27) - ACC_W'(2048)) begin
      q = 16'h7fff;
    end else begin
      q = rounded[VAL_W-1:0];
    end
    scaled = 32'(q ^ 16'h8000) * 32'(SIGMOID_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      idx <= scaled[16 +: IDX_W];
    end
  end

  assign result = SIG_TABLE[idx];

endmodule

// File: hw/rtl/mlp_sigmoid_inference_top.sv
// Channel   | handshake                | payload
// input     | in_valid / in_stall      | mode target_layer source_node dest_node value last_input
// output    | out_valid / out_stall    | node_index activation last
// config    | cfg_write                | cfg_index cfg_data
// Load requests are taken while idle. A last input starts a run that holds in_stall high
// through every layer: a multiply-accumulate loop over the previous layer's nodes, two flush
// steps, then a drain and write-back step per node via the shared sigmoid unit at the head of
// the cell row. A stalled result holds the run in write-back. Reset is synchronous, active high.
module mlp_sigmoid_inference_top #(
  parameter int MAX_LAYERS = 4,
  parameter int MAX_NODES = 16,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [1:0]  target_layer,
  input  logic [3:0]  source_node,
  input  logic [3:0]  dest_node,
  input  logic signed [15:0] value,
  input  logic        last_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  node_index,
  output logic [12:0] activation,
  output logic        last,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);
  import msi_pkg::*;

  localparam int NODE_CAP = (MAX_NODES < 16) ? MAX_NODES : 16;
  localparam int LAYER_CAP = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
  localparam int WDEPTH = (LAYER_CAP - 1) * NODE_CAP;
  localparam int BDEPTH = LAYER_CAP - 1;
  localparam int NAW = $clog2(NODE_CAP);
  localparam int CNT_W = $clog2(NODE_CAP + 1);
  localparam int WAW = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  logic [2:0] layer_count;
  logic [4:0] sizes [4];

  state_t state, state_next;
  logic [1:0] layer, layer_next;
  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] k, k_next;
  logic issue, sig_load, shift, hid_we, out_load;
  logic v1, f1, v2, f2;
  logic use_in;

  logic [2:0] nlayers;
  logic [CNT_W-1:0] prev_size, cur_size;
  logic final_layer;

  logic accept;
  logic wt_we_any, bias_we_any, in_we;
  logic [WAW-1:0] wt_waddr, wt_raddr;
  logic [BAW-1:0] bias_waddr, bias_raddr;

  logic [VAL_W-1:0] in_rd, hid_rd;
  logic signed [VAL_W-1:0] act_rd;
  logic signed [ACC_W-1:0] acc_w [NODE_CAP + 1];
  logic [ACT_W-1:0] sig_out;
  cell_ctl_t ctl;

  function automatic logic [CNT_W-1:0] size_of(input logic [4:0] v);
    if (v == 5'd0) begin
      return CNT_W'(1);
    end else if (32'(v) > NODE_CAP) begin
      return CNT_W'(NODE_CAP);
    end
    return CNT_W'(v);
  endfunction

  assign nlayers = (layer_count < 3'd2) ? 3'd2 :
                   ((32'(layer_count) > LAYER_CAP) ? 3'(LAYER_CAP) : layer_count);
  assign prev_size = size_of(sizes[layer - 2'd1]);
  assign cur_size = size_of(sizes[layer]);
  assign final_layer = ({1'b0, layer} == nlayers - 3'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd2;
      for (int i = 0; i < 4; i++) begin
        sizes[i] <= 5'd16;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LAYER_COUNT: layer_count <= cfg_data[2:0];
        REG_SIZE0: sizes[0] <= cfg_data;
        REG_SIZE1: sizes[1] <= cfg_data;
        REG_SIZE2: sizes[2] <= cfg_data;
        REG_SIZE3: sizes[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign accept = in_valid && !in_stall;

  assign wt_we_any = accept && mode == MODE_WEIGHT && target_layer != 2'd0 &&
                     32'(target_layer) < LAYER_CAP && 32'(dest_node) < NODE_CAP &&
                     32'(source_node) < NODE_CAP;
  assign bias_we_any = accept && mode == MODE_BIAS && target_layer != 2'd0 &&
                       32'(target_layer) < LAYER_CAP && 32'(dest_node) < NODE_CAP;
  assign in_we = accept && mode == MODE_INPUT && 32'(source_node) < NODE_CAP;

  assign wt_waddr = WAW'((32'(target_layer) - 32'd1) * NODE_CAP + 32'(source_node));
  assign bias_waddr = BAW'(target_layer - 2'd1);
  assign wt_raddr = WAW'((32'(layer) - 32'd1) * NODE_CAP + 32'(j));
  assign bias_raddr = BAW'(layer - 2'd1);

  msi_ram #(.WIDTH(VAL_W), .DEPTH(NODE_CAP), .AW(NAW)) u_in_ram (
    .clk(clk), .we(in_we), .waddr(source_node[NAW-1:0]), .wdata(value),
    .raddr(j[NAW-1:0]), .rdata(in_rd)
  );

  msi_ram #(.WIDTH(VAL_W), .DEPTH(NODE_CAP), .AW(NAW)) u_hid_ram (
    .clk(clk), .we(hid_we), .waddr(k[NAW-1:0]), .wdata(VAL_W'(sig_out)),
    .raddr(j[NAW-1:0]), .rdata(hid_rd)
  );

  assign act_rd = use_in ? $signed(in_rd) : $signed(hid_rd);
  assign ctl = '{acc_en: v2, first: f2, shift: shift};

  assign acc_w[NODE_CAP] = '0;

  for (genvar c = 0; c < NODE_CAP; c++) begin : g_cell
    msi_cell #(.WDEPTH(WDEPTH), .BDEPTH(BDEPTH), .WAW(WAW), .BAW(BAW)) u_cell (
      .clk(clk),
      .ctl(ctl),
      .wt_we(wt_we_any && 32'(dest_node) == c),
      .wt_waddr(wt_waddr),
      .bias_we(bias_we_any && 32'(dest_node) == c),
      .bias_waddr(bias_waddr),
      .wdata(value),
      .wt_raddr(wt_raddr),
      .bias_raddr(bias_raddr),
      .act(act_rd),
      .acc_in(acc_w[c + 1]),
      .acc(acc_w[c])
    );
  end

  msi_sigmoid #(.SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)) u_sig (
    .clk(clk), .load(sig_load), .acc(acc_w[0]), .result(sig_out)
  );

  always_comb begin
    state_next = state;
    layer_next = layer;
    j_next = j;
    k_next = k;
    issue = 1'b0;
    sig_load = 1'b0;
    shift = 1'b0;
    hid_we = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept && mode == MODE_INPUT && last_input) begin
          layer_next = 2'd1;
          j_next = '0;
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        if (j == prev_size - CNT_W'(1)) begin
          state_next = ST_FLUSH1;
        end else begin
          j_next = j + CNT_W'(1);
        end
      end
      ST_FLUSH1: state_next = ST_FLUSH2;
      ST_FLUSH2: begin
        k_next = '0;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        sig_load = 1'b1;
        shift = 1'b1;
        state_next = ST_WB;
      end
      ST_WB: begin
        if (!final_layer || !out_valid || !out_stall) begin
          out_load = final_layer;
          hid_we = !final_layer;
          if (k == cur_size - CNT_W'(1)) begin
            if (final_layer) begin
              state_next = ST_IDLE;
            end else begin
              layer_next = layer + 2'd1;
              j_next = '0;
              state_next = ST_MAC;
            end
          end else begin
            k_next = k + CNT_W'(1);
            state_next = ST_DRAIN;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      layer <= 2'd1;
      j <= '0;
      k <= '0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      f1 <= 1'b0;
      f2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      layer <= layer_next;
      j <= j_next;
      k <= k_next;
      v1 <= issue;
      f1 <= issue && j == '0;
      v2 <= v1;
      f2 <= f1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    use_in <= (layer == 2'd1);
    if (out_load) begin
      node_index <= 4'(k);
      activation <= sig_out;
      last <= (k == cur_size - CNT_W'(1));
    end
  end

endmodule

// File: hw/rtl/msi_checker.sv
module msi_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  node_index,
  input logic [12:0] activation,
  input logic        last
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output request present after reset");

  a_act_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> activation <= 13'd4096)
    else $error("activation above one");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input taken in the middle of a run");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(node_index) && $stable(activation))
    else $error("stalled output request changed");

endmodule

bind mlp_sigmoid_inference_top msi_checker u_msi_checker (.*);
